// File: src/dee_pkg.sv
// Shared types and constants of the double excitation enumerator.
package dee_pkg;

  localparam int unsigned MaxOrbitals  = 64;
  localparam int unsigned MaxElectrons = 64;
  localparam int unsigned LabelBits    = 3;
  localparam int unsigned OrbW         = 7;
  localparam int unsigned AddrW        = 6;
  localparam int unsigned VirtW        = 8;
  localparam int unsigned CountW       = 21;
  localparam int unsigned WordW        = 64;
  localparam int unsigned CfgIdxW      = 1;

  localparam logic [OrbW-1:0]   OrbitalsSat  = OrbW'(MaxOrbitals);
  localparam logic [OrbW-1:0]   ElectronsSat = OrbW'(MaxElectrons);
  localparam logic [CountW-1:0] CountMax     = '1;

  typedef enum logic [2:0] {
    OP_WR_LABEL = 3'd0,
    OP_WR_OCC   = 3'd1,
    OP_WR_WORD  = 3'd2,
    OP_START    = 3'd3,
    OP_NEXT     = 3'd4
  } opcode_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_ORBITALS  = 1'b0,
    CFG_ELECTRONS = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [2:0]       opcode;
    logic [5:0]       entry_index;
    logic [2:0]       symmetry_label;
    logic [OrbW-1:0]  occupied_orbital;
    logic [WordW-1:0] occupancy_word;
  } req_t;

  typedef struct packed {
    logic              found;
    logic [OrbW-1:0]   from_first;
    logic [OrbW-1:0]   from_second;
    logic [OrbW-1:0]   to_first;
    logic [OrbW-1:0]   to_second;
    logic              done_res;
    logic [CountW-1:0] total_found;
  } res_t;

  typedef struct packed {
    logic                 lbl_we;
    logic [AddrW-1:0]     lbl_waddr;
    logic [LabelBits-1:0] lbl_wdata;
    logic                 occ_we;
    logic [AddrW-1:0]     occ_waddr;
    logic [OrbW-1:0]      occ_wdata;
    logic                 word_we;
    logic                 word_sel;
    logic [WordW-1:0]     word_data;
    logic [AddrW-1:0]     occ_raddr;
    logic [AddrW-1:0]     lbl_raddr;
    logic [VirtW-1:0]     virt_a;
    logic [VirtW-1:0]     virt_b;
  } store_req_t;

  typedef struct packed {
    logic [OrbW-1:0]      occ_rdata;
    logic [LabelBits-1:0] lbl_rdata;
    logic                 a_taken;
    logic                 b_taken;
  } store_rsp_t;

endpackage

// File: src/dee_store.sv
// Label table and occupied list with registered read ports, and occupancy string with combinational bit lookups.
module dee_store (
  input  logic                clk_i,
  input  dee_pkg::store_req_t req_i,
  output dee_pkg::store_rsp_t rsp_o
);
  import dee_pkg::*;

  logic [LabelBits-1:0] lbl_mem [MaxOrbitals];
  logic [OrbW-1:0]      occ_mem [MaxElectrons];
  logic [2*WordW-1:0]   occ_bits_q;
  logic [LabelBits-1:0] lbl_rdata_q;
  logic [OrbW-1:0]      occ_rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.lbl_we) begin
      lbl_mem[req_i.lbl_waddr] <= req_i.lbl_wdata;
    end
    lbl_rdata_q <= lbl_mem[req_i.lbl_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (req_i.occ_we) begin
      occ_mem[req_i.occ_waddr] <= req_i.occ_wdata;
    end
    occ_rdata_q <= occ_mem[req_i.occ_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (req_i.word_we) begin
      if (req_i.word_sel) begin
        occ_bits_q[2*WordW-1:WordW] <= req_i.word_data;
      end else begin
        occ_bits_q[WordW-1:0] <= req_i.word_data;
      end
    end
  end

  // bits from 128 upward read as empty
  always_comb begin
    rsp_o.occ_rdata = occ_rdata_q;
    rsp_o.lbl_rdata = lbl_rdata_q;
    rsp_o.a_taken   = ~req_i.virt_a[VirtW-1] & occ_bits_q[req_i.virt_a[VirtW-2:0]];
    rsp_o.b_taken   = ~req_i.virt_b[VirtW-1] & occ_bits_q[req_i.virt_b[VirtW-2:0]];
  end

endmodule

// File: src/dee_seq.sv
// Walk sequencer: position counters, bounds stepping, label XOR and result register.
module dee_seq (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  dee_pkg::req_t               req_i,
  output logic                        busy_o,
  input  logic                        cfg_we_i,
  input  logic [dee_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [dee_pkg::OrbW-1:0]    cfg_data_i,
  output dee_pkg::store_req_t         store_o,
  input  dee_pkg::store_rsp_t         store_i,
  output logic                        valid_o,
  output dee_pkg::res_t               res_o
);
  import dee_pkg::*;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_SCAN  = 7'b0000010,
    ST_RD_J  = 7'b0000100,
    ST_LBL_J = 7'b0001000,
    ST_LBL_K = 7'b0010000,
    ST_LBL_L = 7'b0100000,
    ST_CHK   = 7'b1000000
  } state_e;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_OPP  = 2'd1,
    PH_UP   = 2'd2,
    PH_DN   = 2'd3
  } phase_e;

  state_e               state_q, state_d;
  phase_e               phase_q, phase_d;
  logic [OrbW-1:0]      outer_q, outer_d, inner_q, inner_d;
  logic [VirtW-1:0]     vfirst_q, vfirst_d, vsecond_q, vsecond_d;
  logic [CountW-1:0]    count_q, count_d;
  logic [OrbW-1:0]      n_q, ne_q;
  logic [OrbW-1:0]      io_q, io_d, jo_q, jo_d;
  logic [LabelBits-1:0] acc_q, acc_d;
  logic                 ok_q, ok_d;
  logic                 valid_q, valid_d;
  res_t                 res_q, res_d;

  logic [OrbW-1:0]      h, ihi, jhi;
  logic [VirtW-1:0]     n8, klo, khi, lhi, sec_base;
  logic [OrbW-1:0]      lbl_orb, lbl_off, spatial;
  logic [LabelBits-1:0] lbl_val, x;
  logic                 accept;
  opcode_e              op;

  assign accept = start_i & (state_q == ST_IDLE);
  assign op     = opcode_e'(req_i.opcode);
  assign h      = {1'b0, ne_q[OrbW-1:1]};
  assign n8     = {1'b0, n_q};

  always_comb begin
    case (phase_q)
      PH_OPP: begin
        ihi = h;    jhi = ne_q; klo = '0; khi = n8;          lhi = {n_q, 1'b0};
      end
      PH_UP: begin
        ihi = h;    jhi = h;    klo = '0; khi = n8;          lhi = n8;
      end
      default: begin
        ihi = ne_q; jhi = ne_q; klo = n8; khi = {n_q, 1'b0}; lhi = {n_q, 1'b0};
      end
    endcase
    sec_base = (phase_q == PH_OPP) ? n8 : klo + VirtW'(1);
  end

  assign spatial = lbl_orb - lbl_off;
  assign lbl_val = ok_q ? store_i.lbl_rdata : '0;
  assign x       = acc_q ^ lbl_val;

  always_comb begin
    state_d   = state_q;
    phase_d   = phase_q;
    outer_d   = outer_q;
    inner_d   = inner_q;
    vfirst_d  = vfirst_q;
    vsecond_d = vsecond_q;
    count_d   = count_q;
    io_d      = io_q;
    jo_d      = jo_q;
    acc_d     = acc_q;
    ok_d      = ok_q;
    valid_d   = 1'b0;
    res_d     = res_q;
    lbl_orb   = '0;
    lbl_off   = '0;

    store_o           = '0;
    store_o.lbl_waddr = req_i.entry_index;
    store_o.lbl_wdata = req_i.symmetry_label[LabelBits-1:0];
    store_o.occ_waddr = req_i.entry_index;
    store_o.occ_wdata = req_i.occupied_orbital;
    store_o.word_sel  = req_i.entry_index[0];
    store_o.word_data = req_i.occupancy_word;
    store_o.occ_raddr = outer_q[AddrW-1:0];
    store_o.virt_a    = vfirst_q;
    store_o.virt_b    = vsecond_q;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (op)
            OP_WR_LABEL: store_o.lbl_we = 1'b1;
            OP_WR_OCC:   store_o.occ_we = 1'b1;
            OP_WR_WORD:  store_o.word_we = (req_i.entry_index[AddrW-1:1] == '0);
            OP_START: begin
              count_d   = '0;
              phase_d   = PH_OPP;
              outer_d   = '0;
              inner_d   = h;
              vfirst_d  = '0;
              vsecond_d = n8;
            end
            OP_NEXT:   state_d = ST_SCAN;
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        if (phase_q == PH_IDLE) begin
          valid_d           = 1'b1;
          res_d             = '0;
          res_d.done_res    = 1'b1;
          res_d.total_found = count_q;
          state_d           = ST_IDLE;
        end else if (outer_q >= ihi) begin
          case (phase_q)
            PH_OPP: begin
              phase_d   = PH_UP;
              outer_d   = '0;
              inner_d   = OrbW'(1);
              vfirst_d  = '0;
              vsecond_d = VirtW'(1);
            end
            PH_UP: begin
              phase_d   = PH_DN;
              outer_d   = h;
              inner_d   = h + OrbW'(1);
              vfirst_d  = n8;
              vsecond_d = n8 + VirtW'(1);
            end
            default: phase_d = PH_IDLE;
          endcase
        end else if (inner_q >= jhi) begin
          outer_d   = outer_q + OrbW'(1);
          inner_d   = (phase_q == PH_OPP) ? h : outer_q + OrbW'(2);
          vfirst_d  = klo;
          vsecond_d = sec_base;
        end else if (vfirst_q >= khi) begin
          inner_d   = inner_q + OrbW'(1);
          vfirst_d  = klo;
          vsecond_d = sec_base;
        end else if (vsecond_q >= lhi) begin
          vfirst_d  = vfirst_q + VirtW'(1);
          vsecond_d = (phase_q == PH_OPP) ? n8 : vfirst_q + VirtW'(2);
        end else if (store_i.a_taken || store_i.b_taken) begin
          vsecond_d = vsecond_q + VirtW'(1);
        end else begin
          state_d = ST_RD_J;
        end
      end
      ST_RD_J: begin
        store_o.occ_raddr = inner_q[AddrW-1:0];
        io_d    = store_i.occ_rdata;
        lbl_orb = store_i.occ_rdata;
        lbl_off = (phase_q == PH_DN) ? n_q : '0;
        ok_d    = ~spatial[OrbW-1];
        state_d = ST_LBL_J;
      end
      ST_LBL_J: begin
        jo_d    = store_i.occ_rdata;
        lbl_orb = store_i.occ_rdata;
        lbl_off = (phase_q == PH_UP) ? '0 : n_q;
        acc_d   = lbl_val;
        ok_d    = ~spatial[OrbW-1];
        state_d = ST_LBL_K;
      end
      ST_LBL_K: begin
        lbl_orb = vfirst_q[OrbW-1:0];
        lbl_off = (phase_q == PH_DN) ? n_q : '0;
        acc_d   = x;
        ok_d    = ~spatial[OrbW-1];
        state_d = ST_LBL_L;
      end
      ST_LBL_L: begin
        lbl_orb = vsecond_q[OrbW-1:0];
        lbl_off = (phase_q == PH_UP) ? '0 : n_q;
        acc_d   = x;
        ok_d    = ~spatial[OrbW-1];
        state_d = ST_CHK;
      end
      ST_CHK: begin
        vsecond_d = vsecond_q + VirtW'(1);
        if (x == '0) begin
          count_d           = (count_q == CountMax) ? count_q : count_q + CountW'(1);
          valid_d           = 1'b1;
          res_d.found       = 1'b1;
          res_d.from_first  = io_q;
          res_d.from_second = jo_q;
          res_d.to_first    = vfirst_q[OrbW-1:0];
          res_d.to_second   = vsecond_q[OrbW-1:0];
          res_d.done_res    = 1'b0;
          res_d.total_found = count_d;
          state_d           = ST_IDLE;
        end else begin
          state_d = ST_SCAN;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    store_o.lbl_raddr = spatial[AddrW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      phase_q   <= PH_IDLE;
      outer_q   <= '0;
      inner_q   <= '0;
      vfirst_q  <= '0;
      vsecond_q <= '0;
      count_q   <= '0;
      valid_q   <= 1'b0;
      n_q       <= OrbitalsSat;
      ne_q      <= '0;
    end else begin
      state_q   <= state_d;
      phase_q   <= phase_d;
      outer_q   <= outer_d;
      inner_q   <= inner_d;
      vfirst_q  <= vfirst_d;
      vsecond_q <= vsecond_d;
      count_q   <= count_d;
      valid_q   <= valid_d;
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_ORBITALS:  n_q  <= (cfg_data_i > OrbitalsSat) ? OrbitalsSat : cfg_data_i;
          CFG_ELECTRONS: ne_q <= (cfg_data_i > ElectronsSat) ? ElectronsSat : cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    io_q  <= io_d;
    jo_q  <= jo_d;
    acc_q <= acc_d;
    ok_q  <= ok_d;
    res_q <= res_d;
  end

  assign busy_o  = (state_q != ST_IDLE);
  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

// File: src/double_excitation_enumerator_top.sv
// Top level of the symmetry-allowed double excitation enumerator.
// A request is taken when start_i is high and busy_o is low; req_i carries
// opcode, entry index, label, occupied orbital and occupancy word.
// Label, occupied-entry and occupancy-word writes and the start command
// finish in the cycle they are taken and give no result.
// A next request raises busy_o and gives exactly one result, shown on res_o
// for one cycle with valid_o high; busy_o is low again in that same cycle.
// Each skipped bound step or occupied virtual pair takes one scan step; each
// candidate with both virtuals empty then runs two list reads and four label
// reads through single-ported tables (RD_J, LBL_J, LBL_K, LBL_L) and a check
// state, CHK, before the result is registered.
// cfg_we_i/cfg_idx_i/cfg_data_i write orbital_count (0) or electron_count (1)
// at once; write only while busy_o is low.
// Reset: walk idle, count zero, orbital_count 64, electron_count 0; tables
// keep no reset value and must be written before use.
// The receiver cannot stall: take res_o whenever valid_o is high.
module double_excitation_enumerator_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  dee_pkg::req_t               req_i,
  output logic                        busy_o,
  input  logic                        cfg_we_i,
  input  logic [dee_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [dee_pkg::OrbW-1:0]    cfg_data_i,
  output logic                        valid_o,
  output dee_pkg::res_t               res_o
);
  import dee_pkg::*;

  store_req_t store_req;
  store_rsp_t store_rsp;

  dee_store u_store (
    .clk_i (clk_i),
    .req_i (store_req),
    .rsp_o (store_rsp)
  );

  dee_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .req_i      (req_i),
    .busy_o     (busy_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .store_o    (store_req),
    .store_i    (store_rsp),
    .valid_o    (valid_o),
    .res_o      (res_o)
  );

endmodule

// File: src/dee_checker.sv
// Port-level checks for the enumerator top level, bound to it.
module dee_port_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        start_i,
  input dee_pkg::req_t               req_i,
  input logic                        busy_o,
  input logic                        valid_o,
  input dee_pkg::res_t               res_o
);
  import dee_pkg::*;

  logic next_req;
  assign next_req = start_i & ~busy_o & (req_i.opcode == OP_NEXT);

  a_next_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    next_req |=> busy_o)
    else $error("next request did not raise busy");

  a_busy_ends_with_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_o) |-> valid_o)
    else $error("busy dropped without a result");

  a_result_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> !busy_o && $past(busy_o))
    else $error("result outside a next request");

  a_found_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && res_o.found |-> !res_o.done_res && (res_o.total_found != '0))
    else $error("found result with done or zero count");

  a_done_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && res_o.done_res |-> !res_o.found && (res_o.from_first == '0) &&
      (res_o.from_second == '0) && (res_o.to_first == '0) && (res_o.to_second == '0))
    else $error("done result carries orbital fields");

endmodule

bind double_excitation_enumerator_top dee_port_checker u_dee_checker (.*);
